>>> hdl/gradient_noise_2d_3d_macros.svh
// ----------------------------------------------------------------------------
// Gradient noise assertion macros
// Shared concurrent assertion wrappers for the gradient noise block.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_2D_3D_MACROS_SVH
`define GRADIENT_NOISE_2D_3D_MACROS_SVH

// Assertion that is switched off while reset is high.
`define GN23_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gradient noise assertion failed");

// Assertion that is also checked during reset.
`define GN23_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("gradient noise reset assertion failed");

`endif

>>> hdl/gn23_pkg.sv
// ----------------------------------------------------------------------------
// Gradient noise package
// Widths, the permutation table and the corner gradient function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gn23_pkg;

   localparam int FB = 16;
   localparam int ONE = 1 << FB;
   localparam int COORD_W = 32;
   localparam int OUT_W = 18;
   localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
   localparam int OUT_MIN = -(1 << (OUT_W - 1));
   localparam int IN_W = FB + 6;
   localparam int FADE_W = FB + 3;
   localparam int G_W = FB + 3;
   localparam int L_W = (FB + 5 > OUT_W + 1) ? FB + 5 : OUT_W + 1;
   localparam int P_W = FADE_W + L_W + 1;
   localparam int QD = 4;
   localparam int QA_W = $clog2(QD);

   typedef struct packed {
      logic [2:0][7:0]    grid;
      logic [2:0][FB-1:0] frac;
   } pt_type;

   localparam logic [7:0] PERM_TAB [256] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
      8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
      8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
      8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
      8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
      8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
      8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,
      8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,
      8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,
      8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,
      8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,
      8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,
      8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,
      8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,
      8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
      8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,
      8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,
      8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,
      8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,
      8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
      8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,
      8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
   };

   function automatic logic [7:0] perm(input logic [7:0] idx);
      return PERM_TAB[idx];
   endfunction

   function automatic logic signed [G_W-1:0] grad(input logic [3:0] h,
                                                  input logic signed [G_W-1:0] x,
                                                  input logic signed [G_W-1:0] y,
                                                  input logic signed [G_W-1:0] z);
      logic signed [G_W-1:0] u;
      logic signed [G_W-1:0] v;
      u = (h < 4'd8) ? x : y;
      if (h < 4'd4) begin
         v = y;
      end else if (h == 4'd12 || h == 4'd14) begin
         v = x;
      end else begin
         v = z;
      end
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

endpackage

>>> hdl/gn23_if.sv
// ----------------------------------------------------------------------------
// Gradient noise channels
// Valid/ready interfaces for the point and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gn23_req_if;
   logic                              valid;
   logic                              ready;
   logic                              func;
   logic signed [gn23_pkg::COORD_W-1:0] coord_x;
   logic signed [gn23_pkg::COORD_W-1:0] coord_y;
   logic signed [gn23_pkg::COORD_W-1:0] coord_z;
   modport source (output valid, func, coord_x, coord_y, coord_z, input ready);
   modport sink (input valid, func, coord_x, coord_y, coord_z, output ready);
endinterface

interface gn23_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [gn23_pkg::OUT_W-1:0] noise_value;
   modport source (output valid, noise_value, input ready);
   modport sink (input valid, noise_value, output ready);
endinterface

>>> hdl/gn23_front.sv
// ----------------------------------------------------------------------------
// Gradient noise front end
// Accepts a point, splits each coordinate into cell and fraction; z is zero when func is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gn23_front (
   input  logic              clock,
   input  logic              reset,
   gn23_req_if.sink          req,
   input  logic              q_full,
   output logic              q_push,
   output gn23_pkg::pt_type  q_data
);

   logic             v_ff, v_in;
   gn23_pkg::pt_type pt_ff, pt_in;
   logic [gn23_pkg::COORD_W-1:0] cz;

   assign q_push = v_ff && !q_full;
   assign q_data = pt_ff;
   assign req.ready = !v_ff || !q_full;

   always_comb begin
      cz = req.func ? req.coord_z : '0;
      pt_in.grid[0] = req.coord_x[gn23_pkg::FB+7:gn23_pkg::FB];
      pt_in.grid[1] = req.coord_y[gn23_pkg::FB+7:gn23_pkg::FB];
      pt_in.grid[2] = cz[gn23_pkg::FB+7:gn23_pkg::FB];
      pt_in.frac[0] = req.coord_x[gn23_pkg::FB-1:0];
      pt_in.frac[1] = req.coord_y[gn23_pkg::FB-1:0];
      pt_in.frac[2] = cz[gn23_pkg::FB-1:0];
      v_in = req.ready ? req.valid : v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      if (req.ready && req.valid) begin
         pt_ff <= pt_in;
      end
   end

endmodule

>>> hdl/gn23_queue.sv
// ----------------------------------------------------------------------------
// Gradient noise point queue
// Short first-in first-out store between the front end and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gn23_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gn23_pkg::pt_type  push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output gn23_pkg::pt_type  pop_data
);

   gn23_pkg::pt_type mem [gn23_pkg::QD];
   logic [gn23_pkg::QA_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [gn23_pkg::QA_W:0]   cnt_ff, cnt_in;

   assign full = (cnt_ff == (gn23_pkg::QA_W+1)'(gn23_pkg::QD));
   assign not_empty = (cnt_ff != '0);
   assign pop_data = mem[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (gn23_pkg::QA_W+1)'(push) - (gn23_pkg::QA_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/gn23_back.sv
// ----------------------------------------------------------------------------
// Gradient noise datapath
// Ten-stage pipeline: hashing, fade curves, gradients and interpolation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gn23_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  gn23_pkg::pt_type  q_data,
   output logic              q_pop,
   gn23_rsp_if.source        rsp
);

   localparam int FB = gn23_pkg::FB;
   localparam int IN_W = gn23_pkg::IN_W;
   localparam int FADE_W = gn23_pkg::FADE_W;
   localparam int G_W = gn23_pkg::G_W;
   localparam int L_W = gn23_pkg::L_W;
   localparam int P_W = gn23_pkg::P_W;

   logic [10:1] v_ff, v_in;
   logic        en;

   logic [2:0][FB-1:0]           t1_ff, t2_ff, t3_ff;
   logic [2:0][FB-1:0]           sq1_ff, cube2_ff;
   logic signed [IN_W-1:0]       inner1_ff [3];
   logic signed [IN_W-1:0]       inner2_ff [3];
   logic [8:0]                   a1_ff, b1_ff;
   logic [7:0]                   c2_1_ff;
   logic [8:0]                   hx2_ff [4];
   logic [7:0]                   h3_ff [8];
   logic signed [FADE_W-1:0]     f3_ff [3];
   logic signed [FADE_W-1:0]     f4_ff [3];
   logic signed [FADE_W-1:0]     f5_ff [2];
   logic signed [FADE_W-1:0]     f6_ff [2];
   logic signed [FADE_W-1:0]     f7_ff, f8_ff;
   logic signed [G_W-1:0]        g4_ff [8];
   logic signed [G_W-1:0]        g5_ff [4];
   logic signed [P_W-1:0]        p5_ff [4];
   logic signed [L_W-1:0]        l6_ff [4];
   logic signed [L_W-1:0]        l7_ff [2];
   logic signed [P_W-1:0]        p7_ff [2];
   logic signed [L_W-1:0]        n8_ff [2];
   logic signed [L_W-1:0]        n9_ff;
   logic signed [P_W-1:0]        p9_ff;
   logic signed [gn23_pkg::OUT_W-1:0] r10_ff;

   logic signed [IN_W-1:0]       inner1_in [3];
   logic [2:0][FB-1:0]           sq1_in, cube2_in;
   logic signed [FADE_W-1:0]     f3_in [3];
   logic signed [G_W-1:0]        g4_in [8];
   logic signed [P_W-1:0]        p5_in [4];
   logic signed [L_W-1:0]        l6_in [4];
   logic signed [P_W-1:0]        p7_in [2];
   logic signed [L_W-1:0]        n8_in [2];
   logic signed [P_W-1:0]        p9_in;
   logic signed [L_W-1:0]        r_full;
   logic signed [gn23_pkg::OUT_W-1:0] r10_in;
   logic [8:0]                   a1_in, b1_in;
   logic [8:0]                   hx2_in [4];
   logic [7:0]                   h3_in [8];

   assign en = !v_ff[10] || rsp.ready;
   assign q_pop = en && q_not_empty;
   assign rsp.valid = v_ff[10];
   assign rsp.noise_value = r10_ff;

   always_comb begin
      logic [FB+4:0]              t5;
      logic signed [FB+4:0]       m6;
      logic signed [2*FB+6:0]     ip;
      logic [2*FB-1:0]            tt;
      logic [2*FB-1:0]            ct;
      logic signed [FB+IN_W:0]    fp;
      logic signed [G_W-1:0]      cx, cy, cz;
      logic signed [L_W:0]        d;
      v_in = {v_ff[9:1], q_not_empty};
      for (int k = 0; k < 3; k++) begin
         t5 = {5'b0, q_data.frac[k]};
         m6 = $signed(t5 * (FB+5)'(6) - (FB+5)'(15 * gn23_pkg::ONE));
         ip = $signed({1'b0, q_data.frac[k]}) * m6;
         inner1_in[k] = IN_W'(ip >>> FB) + IN_W'(10 * gn23_pkg::ONE);
         tt = q_data.frac[k] * q_data.frac[k];
         sq1_in[k] = tt[2*FB-1:FB];
         ct = sq1_ff[k] * t1_ff[k];
         cube2_in[k] = ct[2*FB-1:FB];
         fp = $signed({1'b0, cube2_ff[k]}) * inner2_ff[k];
         f3_in[k] = FADE_W'(fp >>> FB);
      end
      a1_in = {1'b0, gn23_pkg::perm(q_data.grid[0])} + {1'b0, q_data.grid[1]};
      b1_in = {1'b0, gn23_pkg::perm(q_data.grid[0] + 8'd1)} + {1'b0, q_data.grid[1]};
      hx2_in[0] = {1'b0, gn23_pkg::perm(a1_ff[7:0])} + {1'b0, c2_1_ff};
      hx2_in[1] = {1'b0, gn23_pkg::perm(b1_ff[7:0])} + {1'b0, c2_1_ff};
      hx2_in[2] = {1'b0, gn23_pkg::perm(a1_ff[7:0] + 8'd1)} + {1'b0, c2_1_ff};
      hx2_in[3] = {1'b0, gn23_pkg::perm(b1_ff[7:0] + 8'd1)} + {1'b0, c2_1_ff};
      for (int i = 0; i < 4; i++) begin
         h3_in[i] = gn23_pkg::perm(hx2_ff[i][7:0]);
         h3_in[i+4] = gn23_pkg::perm(hx2_ff[i][7:0] + 8'd1);
      end
      for (int i = 0; i < 8; i++) begin
         cx = G_W'({1'b0, t3_ff[0]}) - (i[0] ? G_W'(gn23_pkg::ONE) : G_W'(0));
         cy = G_W'({1'b0, t3_ff[1]}) - (i[1] ? G_W'(gn23_pkg::ONE) : G_W'(0));
         cz = G_W'({1'b0, t3_ff[2]}) - (i[2] ? G_W'(gn23_pkg::ONE) : G_W'(0));
         g4_in[i] = gn23_pkg::grad(h3_ff[i][3:0], cx, cy, cz);
      end
      for (int j = 0; j < 4; j++) begin
         d = (L_W+1)'(g4_ff[2*j+1]) - (L_W+1)'(g4_ff[2*j]);
         p5_in[j] = f4_ff[0] * d;
         l6_in[j] = L_W'(g5_ff[j]) + L_W'(p5_ff[j] >>> FB);
      end
      for (int k = 0; k < 2; k++) begin
         d = (L_W+1)'(l6_ff[2*k+1]) - (L_W+1)'(l6_ff[2*k]);
         p7_in[k] = f6_ff[0] * d;
         n8_in[k] = l7_ff[k] + L_W'(p7_ff[k] >>> FB);
      end
      d = (L_W+1)'(n8_ff[1]) - (L_W+1)'(n8_ff[0]);
      p9_in = f8_ff * d;
      r_full = n9_ff + L_W'(p9_ff >>> FB);
      if (r_full < L_W'(gn23_pkg::OUT_MIN)) begin
         r10_in = gn23_pkg::OUT_W'(gn23_pkg::OUT_MIN);
      end else if (r_full > L_W'(gn23_pkg::OUT_MAX)) begin
         r10_in = gn23_pkg::OUT_W'(gn23_pkg::OUT_MAX);
      end else begin
         r10_in = r_full[gn23_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
      if (en) begin
         t1_ff <= q_data.frac;
         sq1_ff <= sq1_in;
         a1_ff <= a1_in;
         b1_ff <= b1_in;
         c2_1_ff <= q_data.grid[2];
         t2_ff <= t1_ff;
         cube2_ff <= cube2_in;
         t3_ff <= t2_ff;
         for (int k = 0; k < 3; k++) begin
            inner1_ff[k] <= inner1_in[k];
            inner2_ff[k] <= inner1_ff[k];
            f3_ff[k] <= f3_in[k];
            f4_ff[k] <= f3_ff[k];
         end
         hx2_ff <= hx2_in;
         h3_ff <= h3_in;
         g4_ff <= g4_in;
         for (int j = 0; j < 4; j++) begin
            g5_ff[j] <= g4_ff[2*j];
         end
         p5_ff <= p5_in;
         f5_ff[0] <= f4_ff[1];
         f5_ff[1] <= f4_ff[2];
         l6_ff <= l6_in;
         f6_ff <= f5_ff;
         l7_ff[0] <= l6_ff[0];
         l7_ff[1] <= l6_ff[2];
         p7_ff <= p7_in;
         f7_ff <= f6_ff[1];
         n8_ff <= n8_in;
         f8_ff <= f7_ff;
         n9_ff <= n8_ff[0];
         p9_ff <= p9_in;
         r10_ff <= r10_in;
      end
   end

endmodule

>>> hdl/gradient_noise_2d_3d.sv
// A point passes through the front-end register, the queue and the datapath pipeline on its way to the result.
// Throughput: one point per cycle while rsp.ready holds, set by the fully pipelined ten-stage datapath.
// A four-entry queue lets the front end keep accepting while the result is stalled.
// Reset is synchronous and clears all valid flags and queue pointers; no clearing pass.
// ----------------------------------------------------------------------------
// Gradient noise top level
// Improved 2D/3D gradient noise over Q16.16 points, Q2.16 result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gradient_noise_2d_3d (
   input logic         clock,
   input logic         reset,
   gn23_req_if.sink    req,
   gn23_rsp_if.source  rsp
);

   logic             q_full, q_push, q_pop, q_not_empty;
   gn23_pkg::pt_type q_wdata, q_rdata;

   gn23_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_wdata)
   );

   gn23_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_rdata)
   );

   gn23_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_rdata),
      .q_pop       (q_pop),
      .rsp         (rsp)
   );

endmodule

>>> hdl/gn23_checker.sv
// ----------------------------------------------------------------------------
// Gradient noise checker
// Port-level assertions on transaction ordering and reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gradient_noise_2d_3d_macros.svh"

module gn23_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   logic [4:0] cnt_ff, cnt_in;
   logic       acc_in, acc_out;

   assign acc_in = req_valid && req_ready;
   assign acc_out = rsp_valid && rsp_ready;
   assign cnt_in = cnt_ff + 5'(acc_in) - 5'(acc_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   `GN23_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid)
   `GN23_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `GN23_ASSERT(a_no_orphan, clock, reset, rsp_valid |-> cnt_ff != 5'd0)
   `GN23_ASSERT(a_bounded, clock, reset, cnt_ff <= 5'd16)

endmodule

bind gradient_noise_2d_3d gn23_checker u_gn23_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready)
);
